>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files; flow_vector_color_wheel includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication under active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/fvcw_pkg.sv
// ----------------------------------------------------------------------------
// fvcw_pkg
// Types, constants and the color wheel table for the flow color coder.
// ----------------------------------------------------------------------------
package fvcw_pkg;

    localparam int FLOW_W   = 16;
    localparam int CORDIC_N = 15;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_x;
        logic signed [FLOW_W-1:0] flow_y;
        logic                     flow_valid;
    } t_flow_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    localparam logic [15:0] ATAN_TURNS [CORDIC_N] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    localparam logic [15:0] FULL_SCALE = 16'd65280;

    // {red, green, blue} per wheel entry
    localparam logic [23:0] WHEEL [55] = '{
        24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400,
        24'hFF5500, 24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900,
        24'hFFAA00, 24'hFFBB00, 24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
        24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00,
        24'h2BFF00,
        24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
        24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF,
        24'h008CFF, 24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF,
        24'h0018FF,
        24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF,
        24'h6200FF, 24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF,
        24'hC400FF, 24'hD700FF, 24'hEB00FF,
        24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055,
        24'hFF002B
    };

    function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
        return WHEEL[k];
    endfunction

endpackage

>>> rtl/flow_vector_color_wheel.sv
// ----------------------------------------------------------------------------
// flow_vector_color_wheel
// Codes one optical flow vector per pixel as an RGB color from the wheel.
// ----------------------------------------------------------------------------
// Input channel i_flow: i_valid / o_stall, one signed Q8.8 vector per item.
// Output channel o_pix: o_valid / i_stall, one RGB pixel per item.
// Config channel: i_cfg_valid / o_cfg_ready, max_radius in Q8.8; always ready.
// Throughput is one item per cycle while i_stall does not hold the output.
// The pipeline is 54 stages deep: 3 front stages, 32 square root
// stages (one result bit each), 17 divide stages (one quotient bit each) and
// 2 shading stages. The angle runs alongside in 15 CORDIC stages plus wheel
// lookup and blend.
// A stall on a valid output item freezes the whole pipeline and raises o_stall in
// the same cycle, so nothing is lost or repeated.
// Reset clears all stage valid bits and sets max_radius to 2560.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_vector_color_wheel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fvcw_pkg::t_flow_in  i_flow,
    output logic                o_valid,
    input  logic                i_stall,
    output fvcw_pkg::t_pix_out  o_pix,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    localparam int N_ST    = 54;
    localparam int ST_ROOT = 34;
    localparam int ST_DV0  = 35;
    localparam int ST_Q    = 51;
    localparam int ST_CEND = 17;
    localparam int ST_T    = 18;
    localparam int ST_POS  = 19;
    localparam int ST_BL   = 20;
    localparam int ST_MUL  = 52;
    localparam int ST_OUT  = 53;
    localparam int CW      = 35;

    logic               en;
    logic [N_ST-1:0]    r_v;
    logic [15:0]        r_cfg;
    logic [15:0]        m;
    logic [31:0]        r_m2;

    logic signed [15:0] r_x0, r_y0;
    logic               r_fv [0:ST_OUT];
    logic               r_in [2:ST_OUT];
    logic               r_xn [1:ST_CEND];
    logic               r_yn [1:ST_CEND];
    logic               r_zx [1:ST_CEND];
    logic               r_zy [1:ST_CEND];
    logic [16:0]        r_ax, r_ay;
    logic [31:0]        r_xx, r_yy;

    logic [63:0]        r_sn [2:ST_ROOT];
    logic [63:0]        r_sr [2:ST_ROOT];
    logic [63:0]        n_sn [3:ST_ROOT];
    logic [63:0]        n_sr [3:ST_ROOT];

    logic [15:0]        r_dr [ST_DV0:ST_Q];
    logic [16:0]        r_dn [ST_DV0:ST_Q];
    logic [16:0]        r_dq [ST_DV0:ST_Q];
    logic [15:0]        n_dr [ST_DV0:ST_Q];
    logic [16:0]        n_dq [ST_DV0:ST_Q];

    logic signed [CW-1:0] r_cx [2:ST_CEND];
    logic signed [CW-1:0] r_cy [2:ST_CEND];
    logic signed [16:0]   r_cz [2:ST_CEND];
    logic signed [CW-1:0] n_cx [3:ST_CEND];
    logic signed [CW-1:0] n_cy [3:ST_CEND];
    logic signed [16:0]   n_cz [3:ST_CEND];

    logic [15:0]        r_t;
    logic [13:0]        r_pos;
    logic [47:0]        r_bl [ST_BL:ST_MUL];
    logic [16:0]        r_pr [3];
    fvcw_pkg::t_pix_out r_out;

    logic [16:0]        ax0, ay0;
    logic [15:0]        zc;
    logic [16:0]        t17;
    logic [47:0]        n_bl;
    logic [23:0]        w0, w1;
    logic [5:0]         k0;
    logic [7:0]         f;
    logic [16:0]        n_pr [3];
    logic [23:0]        n_out;

    assign en          = !(r_v[ST_OUT] && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_v[ST_OUT];
    assign o_pix       = r_out;
    assign o_cfg_ready = 1'b1;
    assign m           = (r_cfg == 16'd0) ? 16'd1 : r_cfg;

    assign ax0 = r_x0[15] ? 17'(-{r_x0[15], r_x0}) : {1'b0, r_x0};
    assign ay0 = r_y0[15] ? 17'(-{r_y0[15], r_y0}) : {1'b0, r_y0};

    always_comb begin
        logic [63:0] bt;
        logic [63:0] tr;
        for (int i = 0; i < 32; i++) begin
            bt = 64'd1 << (62 - 2 * i);
            tr = r_sr[2+i] + bt;
            if (r_sn[2+i] >= tr) begin
                n_sn[3+i] = r_sn[2+i] - tr;
                n_sr[3+i] = (r_sr[2+i] >> 1) + bt;
            end else begin
                n_sn[3+i] = r_sn[2+i];
                n_sr[3+i] = r_sr[2+i] >> 1;
            end
        end
    end

    always_comb begin
        logic [15:0] rin;
        logic [16:0] qin;
        logic [16:0] trial;
        logic        nb;
        for (int j = 0; j < 17; j++) begin
            if (j == 0) begin
                rin = {1'b0, r_sr[ST_ROOT][31:17]};
                qin = '0;
                nb  = r_sr[ST_ROOT][16];
            end else begin
                rin = r_dr[ST_DV0+j-1];
                qin = r_dq[ST_DV0+j-1];
                nb  = r_dn[ST_DV0+j-1][16-j];
            end
            trial = {rin, nb};
            if (trial >= {1'b0, m}) begin
                n_dr[ST_DV0+j] = 16'(trial - {1'b0, m});
                n_dq[ST_DV0+j] = {qin[15:0], 1'b1};
            end else begin
                n_dr[ST_DV0+j] = trial[15:0];
                n_dq[ST_DV0+j] = {qin[15:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < fvcw_pkg::CORDIC_N; i++) begin
            if (!r_cy[2+i][CW-1]) begin
                n_cx[3+i] = r_cx[2+i] + (r_cy[2+i] >>> i);
                n_cy[3+i] = r_cy[2+i] - (r_cx[2+i] >>> i);
                n_cz[3+i] = r_cz[2+i] + signed'({1'b0, fvcw_pkg::ATAN_TURNS[i]});
            end else begin
                n_cx[3+i] = r_cx[2+i] - (r_cy[2+i] >>> i);
                n_cy[3+i] = r_cy[2+i] + (r_cx[2+i] >>> i);
                n_cz[3+i] = r_cz[2+i] - signed'({1'b0, fvcw_pkg::ATAN_TURNS[i]});
            end
        end
    end

    always_comb begin
        if (r_zy[ST_CEND]) begin
            zc = 16'd0;
        end else if (r_zx[ST_CEND]) begin
            zc = 16'd16384;
        end else if (r_cz[ST_CEND][16]) begin
            zc = 16'd0;
        end else if (r_cz[ST_CEND] > 17'sd16384) begin
            zc = 16'd16384;
        end else begin
            zc = r_cz[ST_CEND][15:0];
        end
        if (!r_xn[ST_CEND] && !r_yn[ST_CEND]) begin
            t17 = {1'b0, zc};
        end else if (r_xn[ST_CEND] && !r_yn[ST_CEND]) begin
            t17 = 17'd32768 - {1'b0, zc};
        end else if (r_xn[ST_CEND]) begin
            t17 = 17'd32768 + {1'b0, zc};
        end else begin
            t17 = 17'd65536 - {1'b0, zc};
        end
    end

    assign k0 = r_pos[13:8];
    assign f  = r_pos[7:0];
    assign w0 = fvcw_pkg::wheel_rgb(k0);
    assign w1 = fvcw_pkg::wheel_rgb(6'(k0 + 6'd1));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_bl[16*c +: 16] = 16'((17'(9'd256 - {1'b0, f}) * 17'(w0[8*c +: 8]))
                                 + (17'(f) * 17'(w1[8*c +: 8])));
        end
    end

    always_comb begin
        logic [32:0] prod;
        logic [15:0] bc;
        for (int c = 0; c < 3; c++) begin
            bc      = r_bl[ST_Q][16*c +: 16];
            prod    = 33'(r_dq[ST_Q]) * 33'(fvcw_pkg::FULL_SCALE - bc);
            n_pr[c] = prod[32:16];
        end
    end

    always_comb begin
        logic [17:0] sc;
        for (int c = 0; c < 3; c++) begin
            sc = 18'd3 * 18'(r_bl[ST_MUL][16*c +: 16]);
            if (!r_fv[ST_MUL]) begin
                n_out[8*c +: 8] = 8'd0;
            end else if (r_in[ST_MUL]) begin
                n_out[8*c +: 8] = 8'((17'(fvcw_pkg::FULL_SCALE) - r_pr[c]) >> 8);
            end else begin
                n_out[8*c +: 8] = 8'(sc >> 10);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 16'd2560;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2 <= 32'({16'd0, m} * {16'd0, m});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0     <= i_flow.flow_x;
            r_y0     <= i_flow.flow_y;
            r_fv[0]  <= i_flow.flow_valid;
            for (int s = 1; s <= ST_OUT; s++) begin
                r_fv[s] <= r_fv[s-1];
            end

            r_ax     <= ax0;
            r_ay     <= ay0;
            r_xx     <= 32'(ax0 * ax0);
            r_yy     <= 32'(ay0 * ay0);
            r_xn[1]  <= r_x0[15];
            r_yn[1]  <= r_y0[15];
            r_zx[1]  <= (r_x0 == 16'sd0);
            r_zy[1]  <= (r_y0 == 16'sd0);
            for (int s = 2; s <= ST_CEND; s++) begin
                r_xn[s] <= r_xn[s-1];
                r_yn[s] <= r_yn[s-1];
                r_zx[s] <= r_zx[s-1];
                r_zy[s] <= r_zy[s-1];
            end

            r_in[2]  <= (33'(r_xx) + 33'(r_yy)) <= 33'(r_m2);
            for (int s = 3; s <= ST_OUT; s++) begin
                r_in[s] <= r_in[s-1];
            end
            r_sn[2]  <= {32'(r_xx + r_yy), 32'd0};
            r_sr[2]  <= '0;
            for (int s = 3; s <= ST_ROOT; s++) begin
                r_sn[s] <= n_sn[s];
                r_sr[s] <= n_sr[s];
            end

            r_dn[ST_DV0] <= r_sr[ST_ROOT][16:0];
            for (int s = ST_DV0 + 1; s <= ST_Q; s++) begin
                r_dn[s] <= r_dn[s-1];
            end
            for (int s = ST_DV0; s <= ST_Q; s++) begin
                r_dr[s] <= n_dr[s];
                r_dq[s] <= n_dq[s];
            end

            r_cx[2]  <= CW'({r_ax, 16'd0});
            r_cy[2]  <= CW'({r_ay, 16'd0});
            r_cz[2]  <= '0;
            for (int s = 3; s <= ST_CEND; s++) begin
                r_cx[s] <= n_cx[s];
                r_cy[s] <= n_cy[s];
                r_cz[s] <= n_cz[s];
            end

            r_t      <= t17[15:0];
            r_pos    <= 14'((22'(r_t) * 22'd54) >> 8);
            r_bl[ST_BL] <= n_bl;
            for (int s = ST_BL + 1; s <= ST_MUL; s++) begin
                r_bl[s] <= r_bl[s-1];
            end
            for (int c = 0; c < 3; c++) begin
                r_pr[c] <= n_pr[c];
            end
            r_out    <= n_out;
        end
    end

    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !en, $stable(r_v))
    `ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && !o_stall, r_v[0])
    `ASSERT_IMPL(a_quot_range, i_clk, i_rst_n, r_v[ST_Q] && r_in[ST_Q], r_dq[ST_Q] <= 17'd65536)
    `ASSERT_IMPL(a_black, i_clk, i_rst_n, r_v[ST_OUT] && !r_fv[ST_OUT], r_out == '0)

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives flow vectors into the color wheel coder through its valid/stall
// handshake, predicts each RGB pixel with a local fixed-point model of the
// wheel shading, and compares every output item against the oldest
// prediction. Runs through several max_radius settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    fvcw_pkg::t_flow_in  i_flow;
    logic                o_valid;
    logic                i_stall;
    fvcw_pkg::t_pix_out  o_pix;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data;

    flow_vector_color_wheel DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_flow(i_flow),
        .o_valid(o_valid), .i_stall(i_stall), .o_pix(o_pix),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    fvcw_pkg::t_flow_in  pending_flow[$];
    fvcw_pkg::t_pix_out  expected_pix[$];
    logic [15:0]         radius_reg;
    int                  errors;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int wheel_chan(int k, int ch);
        logic [23:0] c;
        int r;
        int g;
        int b;
        if (k < 15) begin
            r = 255; g = 255 * k / 15; b = 0;
        end else if (k < 21) begin
            r = 255 - 255 * (k - 15) / 6; g = 255; b = 0;
        end else if (k < 25) begin
            r = 0; g = 255; b = 255 * (k - 21) / 4;
        end else if (k < 36) begin
            r = 0; g = 255 - 255 * (k - 25) / 11; b = 255;
        end else if (k < 49) begin
            r = 255 * (k - 36) / 13; g = 0; b = 255;
        end else begin
            r = 255; g = 0; b = 255 - 255 * (k - 49) / 6;
        end
        c = {8'(r), 8'(g), 8'(b)};
        return ch == 0 ? c[23:16] : (ch == 1 ? c[15:8] : c[7:0]);
    endfunction

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int flow_angle(longint x, longint y);
        longint ax;
        longint ay;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        int     z;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        if (ay == 0) begin
            z = 0;
        end else if (ax == 0) begin
            z = 16384;
        end else begin
            cx = ax * 65536;
            cy = ay * 65536;
            z = 0;
            for (int i = 0; i < fvcw_pkg::CORDIC_N; i++) begin
                dx = floor_shr(cy, i);
                dy = floor_shr(cx, i);
                if (cy >= 0) begin
                    cx += dx; cy -= dy; z += int'(fvcw_pkg::ATAN_TURNS[i]);
                end else begin
                    cx -= dx; cy += dy; z -= int'(fvcw_pkg::ATAN_TURNS[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > 16384) z = 16384;
        end
        if (x >= 0 && y >= 0) return z;
        if (x < 0 && y >= 0) return 32768 - z;
        if (x < 0) return 32768 + z;
        return (65536 - z) & 16'hFFFF;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic fvcw_pkg::t_pix_out shade_pixel(fvcw_pkg::t_flow_in v,
                                                      logic [15:0] radius);
        fvcw_pkg::t_pix_out p;
        longint          x;
        longint          y;
        longint unsigned m;
        longint unsigned s;
        longint unsigned rq;
        longint unsigned bl;
        longint unsigned c;
        int              t;
        int              pos;
        int              k0;
        int              k1;
        int              f;
        bit              within_r;
        p = '0;
        if (!v.flow_valid) return p;
        x = v.flow_x;
        y = v.flow_y;
        m = radius == 0 ? 1 : radius;
        t = flow_angle(x, y);
        pos = (54 * t) >> 8;
        k0 = pos >> 8;
        k1 = (k0 + 1) % 55;
        f = pos & 255;
        s = x * x + y * y;
        within_r = s <= m * m;
        rq = within_r ? root64(s << 32) / m : 0;
        for (int ch = 0; ch < 3; ch++) begin
            bl = (256 - f) * wheel_chan(k0, ch) + f * wheel_chan(k1, ch);
            if (within_r) c = (65280 - ((rq * (65280 - bl)) >> 16)) >> 8;
            else c = (3 * bl) >> 10;
            if (ch == 0) p.red = c[7:0];
            else if (ch == 1) p.green = c[7:0];
            else p.blue = c[7:0];
        end
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void queue_flow(fvcw_pkg::t_flow_in v);
        pending_flow.insert(pending_flow.size(), v);
    endfunction

    // Drive input items at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            i_valid <= 1'b1;
        end else begin
            if (i_valid) void'(pending_flow.pop_front());
            if (pending_flow.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_flow  <= pending_flow[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Predict at acceptance, check at output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_pix.insert(expected_pix.size(), shade_pixel(i_flow, radius_reg));
            if (o_valid && !i_stall) begin
                if (expected_pix.size() == 0) begin
                    report_mismatch("unexpected output item");
                end else begin
                    fvcw_pkg::t_pix_out e;
                    e = expected_pix.pop_front();
                    if (o_pix.red !== e.red)
                        report_mismatch($sformatf("red %0d exp %0d", o_pix.red, e.red));
                    if (o_pix.green !== e.green)
                        report_mismatch($sformatf("green %0d exp %0d", o_pix.green, e.green));
                    if (o_pix.blue !== e.blue)
                        report_mismatch($sformatf("blue %0d exp %0d", o_pix.blue, e.blue));
                end
            end
            if (i_cfg_valid && o_cfg_ready) radius_reg <= i_cfg_data;
        end
    end

    function automatic fvcw_pkg::t_flow_in make_flow(int x, int y, bit ok);
        fvcw_pkg::t_flow_in v;
        v.flow_x = 16'(x);
        v.flow_y = 16'(y);
        v.flow_valid = ok;
        return v;
    endfunction

    function automatic fvcw_pkg::t_flow_in random_flow(logic [15:0] radius);
        int sel;
        int lim;
        sel = $urandom_range(9);
        lim = radius > 200 ? 2 * radius : 400;
        if (lim > 32767) lim = 32767;
        if (sel < 6)
            return make_flow($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                             $urandom_range(15) != 0);
        if (sel < 9)
            return make_flow($urandom, $urandom, 1'b1);
        return make_flow($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(1));
    endfunction

    task automatic drain();
        wait (pending_flow.size() == 0 && !i_valid);
        while (expected_pix.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] radii[6];
        radii = '{16'd2560, 16'd1, 16'd65535, 16'd0, 16'd256, 16'd700};
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 72;
        radius_reg = 16'd2560;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_flow = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_flow(make_flow(0, 0, 1'b1));
        queue_flow(make_flow(0, 0, 1'b0));
        queue_flow(make_flow(32767, 32767, 1'b0));
        queue_flow(make_flow(1000, 0, 1'b1));
        queue_flow(make_flow(-1000, 0, 1'b1));
        queue_flow(make_flow(0, 1000, 1'b1));
        queue_flow(make_flow(0, -1000, 1'b1));
        queue_flow(make_flow(32767, 32767, 1'b1));
        queue_flow(make_flow(-32768, -32768, 1'b1));
        queue_flow(make_flow(-32768, 32767, 1'b1));
        queue_flow(make_flow(32767, -32768, 1'b1));
        queue_flow(make_flow(2560, 0, 1'b1));
        queue_flow(make_flow(2561, 0, 1'b1));
        queue_flow(make_flow(1810, 1810, 1'b1));
        queue_flow(make_flow(-5, 7, 1'b1));
        queue_flow(make_flow(1, -1, 1'b1));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_radius(radii[ph]);
            send_idle_pct = ph < 2 ? 23 : (ph < 4 ? 72 : 0);
            recv_idle_pct = ph < 2 ? 72 : (ph < 4 ? 23 : 0);
            if (ph == 4) hold_cycles = 150;
            for (int n = 0; n < 66; n++) queue_flow(random_flow(radii[ph]));
            drain();
        end

        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

>>> flow_vector_color_wheel.f
+incdir+rtl
rtl/fvcw_pkg.sv
rtl/flow_vector_color_wheel.sv
tb/sv/tb_top.sv
